// File: sv/dsn_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the depth surface normal core.
package dsn_pkg;

  localparam int unsigned SQ_STEPS = 32;
  localparam int unsigned DV_STEPS = 16;
  localparam int unsigned MAG_W    = 15;
  localparam int unsigned FRAC_W   = 30;
  localparam int unsigned RAD_W    = 64;
  localparam int unsigned REM_W    = 34;
  localparam int unsigned ROOT_W   = 32;
  localparam int unsigned DEN_W    = 32;
  localparam int unsigned QUO_W    = 16;
  localparam int unsigned NUM_W    = 46;
  localparam int unsigned COL_W    = 11;
  localparam int unsigned ROW_W    = 12;
  localparam logic [QUO_W-1:0] QMAX = 16'd32767;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic             ok;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
  } meta_t;

  typedef struct packed {
    meta_t                 meta;
    logic [2:0]            sgn;
    logic [2:0][MAG_W-1:0] m;
  } sq_side_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    sq_side_t          side;
  } sq_data_t;

  typedef struct packed {
    meta_t      meta;
    logic [2:0] sgn;
  } dv_side_t;

  typedef struct packed {
    logic [DEN_W-1:0]       den;
    logic [2:0][DEN_W-1:0]  rem;
    logic [2:0][QUO_W-1:0]  low;
    logic [2:0][QUO_W-1:0]  quo;
    dv_side_t               side;
  } dv_data_t;

endpackage

// File: sv/depth_surface_normal_3x3_core.sv
`timescale 1ns / 1ps
// Surface normal estimator over a 3x3 window of an XYZ pixel stream.
// Takes one pixel per clock and gives one result per interior centre, one pixel
// right of and one row below that centre; border pixels give none. From the
// completing pixel to its result lie eight arithmetic stages, a chain of 32
// square-root cells, a setup stage, a chain of 16 divider cells and the output
// register. The whole pipeline holds only while a result waits and out_stall_i
// is high. Two line memories of MAX_LINE_WIDTH entries hold the previous two
// rows; writing image_width or image_height restarts the frame.
module depth_surface_normal_3x3_core import dsn_pkg::*; #(
  parameter int MAX_LINE_WIDTH = 2048,
  parameter int COORD_BITS     = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] x_mm_i,
  input  logic signed [15:0] y_mm_i,
  input  logic signed [15:0] z_mm_i,
  input  logic               pixel_enable_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] normal_x_o,
  output logic signed [15:0] normal_y_o,
  output logic [14:0]        normal_z_o,
  output logic               normal_valid_o,
  output logic [10:0]        center_column_o,
  output logic [11:0]        center_row_o,
  output logic               frame_last_o
);

  localparam int CW = $clog2(MAX_LINE_WIDTH);
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int NW = PW + 1;
  localparam int SW = $clog2(NW);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
    logic                         en;
  } pix_t;

  logic        adv;
  logic        accept;
  logic        cfg_wr;
  logic [11:0] width_q;
  logic [12:0] height_q;
  logic [11:0] wv;
  logic [12:0] hv;
  logic [CW-1:0] col_q;
  logic [11:0]   row_q;
  pix_t        pix_in;
  logic [31:0] xr, yr, zr;

  assign adv        = !(out_valid_o && out_stall_i);
  assign accept     = in_valid_i && adv;
  assign in_stall_o = !adv;
  assign cfg_wr     = psel && penable && pwrite;
  assign pready     = 1'b1;

  // configuration
  assign wv = pwdata[11:0];
  assign hv = pwdata[12:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 12'd640;
      height_q <= 13'd480;
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[2]))
        REG_WIDTH: begin
          if (wv < 12'd3) begin
            width_q <= 12'd3;
          end else if (32'(wv) > 32'(MAX_LINE_WIDTH)) begin
            width_q <= 12'(MAX_LINE_WIDTH);
          end else begin
            width_q <= wv;
          end
        end
        REG_HEIGHT: begin
          if (hv < 13'd3) begin
            height_q <= 13'd3;
          end else if (hv > 13'd4096) begin
            height_q <= 13'd4096;
          end else begin
            height_q <= hv;
          end
        end
        default: begin
          width_q <= width_q;
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[2]))
      REG_WIDTH:  prdata = 32'(width_q);
      REG_HEIGHT: prdata = 32'(height_q);
      default:    prdata = '0;
    endcase
  end

  // position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_wr) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (32'(col_q) + 32'd1 >= 32'(width_q)) begin
        col_q <= '0;
        if (32'(row_q) + 32'd1 >= 32'(height_q)) begin
          row_q <= '0;
        end else begin
          row_q <= row_q + 12'd1;
        end
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  assign xr = {16'd0, x_mm_i};
  assign yr = {16'd0, y_mm_i};
  assign zr = {16'd0, z_mm_i};
  assign pix_in.x  = xr[COORD_BITS-1:0];
  assign pix_in.y  = yr[COORD_BITS-1:0];
  assign pix_in.z  = zr[COORD_BITS-1:0];
  assign pix_in.en = pixel_enable_i;

  // stage 1: accepted pixel and line memory read
  pix_t    upper_mem  [MAX_LINE_WIDTH];
  pix_t    middle_mem [MAX_LINE_WIDTH];
  pix_t    up_rd_q, mid_rd_q;
  logic    s1_v_q;
  pix_t    s1_pix_q;
  logic [CW-1:0] s1_col_q;
  logic    s1_prod_q;
  meta_t   s1_meta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      up_rd_q        <= upper_mem[col_q];
      mid_rd_q       <= middle_mem[col_q];
      s1_pix_q       <= pix_in;
      s1_col_q       <= col_q;
      s1_prod_q      <= (row_q >= 12'd2) && (col_q >= CW'(2));
      s1_meta_q.ok   <= 1'b1;
      s1_meta_q.col  <= COL_W'(col_q - CW'(1));
      s1_meta_q.row  <= row_q - 12'd1;
      s1_meta_q.last <= (32'(row_q) == 32'(height_q) - 32'd1) &&
                        (32'(col_q) == 32'(width_q) - 32'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_v_q) begin
      upper_mem[s1_col_q]  <= mid_rd_q;
      middle_mem[s1_col_q] <= s1_pix_q;
    end
  end

  // window of the two previous columns: up, mid, current row each
  pix_t win_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (adv && s1_v_q) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= up_rd_q;
      win_q[4] <= mid_rd_q;
      win_q[5] <= s1_pix_q;
    end
  end

  function automatic logic is_orig(pix_t p);
    return (p.x == '0) && (p.y == '0) && (p.z == '0);
  endfunction

  // stage 2: corner differences
  logic s1_ok;
  logic signed [DW-1:0] s1_a [3];
  logic signed [DW-1:0] s1_b [3];
  logic  s2_v_q;
  meta_t s2_meta_q;
  logic signed [DW-1:0] s2_a_q [3];
  logic signed [DW-1:0] s2_b_q [3];

  assign s1_ok = win_q[4].en && !is_orig(win_q[0]) && !is_orig(up_rd_q) &&
                 !is_orig(win_q[2]) && !is_orig(s1_pix_q);
  assign s1_a[0] = DW'(up_rd_q.x) - DW'(win_q[2].x);
  assign s1_a[1] = DW'(up_rd_q.y) - DW'(win_q[2].y);
  assign s1_a[2] = DW'(up_rd_q.z) - DW'(win_q[2].z);
  assign s1_b[0] = DW'(win_q[0].x) - DW'(s1_pix_q.x);
  assign s1_b[1] = DW'(win_q[0].y) - DW'(s1_pix_q.y);
  assign s1_b[2] = DW'(win_q[0].z) - DW'(s1_pix_q.z);

  // stage 3: products; stage 4: cross product with flip
  logic  s3_v_q, s4_v_q;
  meta_t s3_meta_q, s4_meta_q;
  logic signed [PW-1:0] s3_p_q [6];
  logic signed [NW-1:0] n [3];
  logic signed [NW-1:0] s4_n_q [3];

  assign n[0] = NW'(s3_p_q[0]) - NW'(s3_p_q[1]);
  assign n[1] = NW'(s3_p_q[2]) - NW'(s3_p_q[3]);
  assign n[2] = NW'(s3_p_q[4]) - NW'(s3_p_q[5]);

  // stage 5: magnitudes, signs and shift amount
  logic [NW-1:0] mag [3];
  logic [NW-1:0] mag_or;
  logic [SW-1:0] shamt;
  logic  s5_v_q;
  meta_t s5_meta_q;
  logic [NW-1:0] s5_mag_q [3];
  logic [2:0]    s5_sgn_q;
  logic [SW-1:0] s5_sh_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = s4_n_q[i][NW-1] ? $unsigned(-s4_n_q[i]) : $unsigned(s4_n_q[i]);
    end
    mag_or = mag[0] | mag[1] | mag[2];
    shamt  = '0;
    for (int i = MAG_W; i < NW; i++) begin
      if (mag_or[i]) begin
        shamt = SW'(i - (MAG_W - 1));
      end
    end
  end

  // stage 6: scaled magnitudes; stage 7: squares; stage 8: sum
  logic  s6_v_q, s7_v_q, s8_v_q;
  sq_side_t s6_side_q, s7_side_q, s8_side_q;
  logic [2*MAG_W-1:0] s7_sq_q [3];
  logic [31:0]        s8_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
      s6_v_q <= 1'b0;
      s7_v_q <= 1'b0;
      s8_v_q <= 1'b0;
    end else if (adv) begin
      s2_v_q <= s1_v_q && s1_prod_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
      s6_v_q <= s5_v_q;
      s7_v_q <= s6_v_q;
      s8_v_q <= s7_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_meta_q <= '{ok: s1_ok, col: s1_meta_q.col, row: s1_meta_q.row,
                     last: s1_meta_q.last};
      s2_a_q    <= s1_a;
      s2_b_q    <= s1_b;

      s3_meta_q <= s2_meta_q;
      s3_p_q[0] <= s2_b_q[1] * s2_a_q[2];
      s3_p_q[1] <= s2_b_q[2] * s2_a_q[1];
      s3_p_q[2] <= s2_b_q[2] * s2_a_q[0];
      s3_p_q[3] <= s2_b_q[0] * s2_a_q[2];
      s3_p_q[4] <= s2_b_q[0] * s2_a_q[1];
      s3_p_q[5] <= s2_b_q[1] * s2_a_q[0];

      s4_meta_q <= s3_meta_q;
      for (int i = 0; i < 3; i++) begin
        s4_n_q[i] <= n[2][NW-1] ? -n[i] : n[i];
      end

      s5_meta_q <= '{ok: s4_meta_q.ok && (mag_or != '0), col: s4_meta_q.col,
                     row: s4_meta_q.row, last: s4_meta_q.last};
      s5_mag_q  <= mag;
      s5_sgn_q  <= {s4_n_q[2][NW-1], s4_n_q[1][NW-1], s4_n_q[0][NW-1]};
      s5_sh_q   <= shamt;

      s6_side_q.meta <= s5_meta_q;
      s6_side_q.sgn  <= s5_sgn_q;
      for (int i = 0; i < 3; i++) begin
        s6_side_q.m[i] <= MAG_W'(s5_mag_q[i] >> s5_sh_q);
      end

      s7_side_q <= s6_side_q;
      for (int i = 0; i < 3; i++) begin
        s7_sq_q[i] <= s6_side_q.m[i] * s6_side_q.m[i];
      end

      s8_side_q <= s7_side_q;
      s8_sum_q  <= 32'(s7_sq_q[0]) + 32'(s7_sq_q[1]) + 32'(s7_sq_q[2]);
    end
  end

  // square-root chain
  sq_data_t              sq_d [SQ_STEPS+1];
  logic [SQ_STEPS:0]     sq_v;

  assign sq_v[0]      = s8_v_q;
  assign sq_d[0].rad  = RAD_W'({s8_sum_q, {FRAC_W{1'b0}}});
  assign sq_d[0].rem  = '0;
  assign sq_d[0].root = '0;
  assign sq_d[0].side = s8_side_q;

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    dsn_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (sq_v[k]),
      .data_i  (sq_d[k]),
      .valid_o (sq_v[k+1]),
      .data_o  (sq_d[k+1])
    );
  end

  // divider setup: numerator is m scaled by 2^30 plus half the root
  logic [NUM_W-1:0] num [3];
  logic             s9_v_q;
  dv_data_t         s9_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = NUM_W'({sq_d[SQ_STEPS].side.m[i], {FRAC_W{1'b0}}}) +
               NUM_W'(sq_d[SQ_STEPS].root[ROOT_W-1:1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s9_v_q <= 1'b0;
    end else if (adv) begin
      s9_v_q <= sq_v[SQ_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s9_q.den       <= sq_d[SQ_STEPS].root;
      s9_q.side.meta <= sq_d[SQ_STEPS].side.meta;
      s9_q.side.sgn  <= sq_d[SQ_STEPS].side.sgn;
      for (int i = 0; i < 3; i++) begin
        s9_q.rem[i] <= DEN_W'(num[i][NUM_W-1:QUO_W]);
        s9_q.low[i] <= num[i][QUO_W-1:0];
        s9_q.quo[i] <= '0;
      end
    end
  end

  // divider chain
  dv_data_t          dv_d [DV_STEPS+1];
  logic [DV_STEPS:0] dv_v;

  assign dv_v[0] = s9_v_q;
  assign dv_d[0] = s9_q;

  for (genvar k = 0; k < DV_STEPS; k++) begin : g_div
    dsn_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (dv_v[k]),
      .data_i  (dv_d[k]),
      .valid_o (dv_v[k+1]),
      .data_o  (dv_d[k+1])
    );
  end

  // output register
  logic [MAG_W-1:0]  qc [3];
  logic signed [15:0] qs [3];
  dv_side_t          fin;
  logic              out_valid_q;
  logic signed [15:0] nx_q, ny_q;
  logic [14:0]       nz_q;
  logic              nv_q, last_q;
  logic [10:0]       col_out_q;
  logic [11:0]       row_out_q;

  assign fin = dv_d[DV_STEPS].side;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc[i] = (dv_d[DV_STEPS].quo[i] > QMAX) ? MAG_W'(QMAX)
                                             : MAG_W'(dv_d[DV_STEPS].quo[i]);
      qs[i] = fin.sgn[i] ? -$signed({1'b0, qc[i]}) : $signed({1'b0, qc[i]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv_v[DV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nv_q      <= fin.meta.ok;
      nx_q      <= fin.meta.ok ? qs[0] : '0;
      ny_q      <= fin.meta.ok ? qs[1] : '0;
      nz_q      <= fin.meta.ok ? qc[2] : '0;
      col_out_q <= fin.meta.col;
      row_out_q <= fin.meta.row;
      last_q    <= fin.meta.last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign normal_x_o      = nx_q;
  assign normal_y_o      = ny_q;
  assign normal_z_o      = nz_q;
  assign normal_valid_o  = nv_q;
  assign center_column_o = col_out_q;
  assign center_row_o    = row_out_q;
  assign frame_last_o    = last_q;

  a_skip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !normal_valid_o |->
      normal_x_o == '0 && normal_y_o == '0 && normal_z_o == '0)
    else $error("skipped result carries a nonzero normal");

  a_no_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> normal_x_o != 16'sh8000 && normal_y_o != 16'sh8000)
    else $error("normal component beyond saturation");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(col_q) < 32'(width_q))
    else $error("column counter beyond image width");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_last_o |->
      32'(center_column_o) == 32'(width_q) - 32'd2)
    else $error("frame end flagged away from last centre column");

endmodule

// File: sv/dsn_sqrt_cell.sv
`timescale 1ns / 1ps
// One restoring square-root step: two radicand bits in, one root bit out.
module dsn_sqrt_cell import dsn_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  sq_data_t data_i,
  output logic     valid_o,
  output sq_data_t data_o
);

  logic [REM_W+1:0] cur;
  logic [REM_W+1:0] trial;
  sq_data_t         data_d;
  sq_data_t         data_q;
  logic             valid_q;

  always_comb begin
    cur    = {data_i.rem, data_i.rad[RAD_W-1 -: 2]};
    trial  = (REM_W+2)'({data_i.root, 2'b01});
    data_d = data_i;
    data_d.rad = data_i.rad << 2;
    if (cur >= trial) begin
      data_d.rem  = REM_W'(cur - trial);
      data_d.root = {data_i.root[ROOT_W-2:0], 1'b1};
    end else begin
      data_d.rem  = REM_W'(cur);
      data_d.root = {data_i.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: sv/dsn_div_cell.sv
`timescale 1ns / 1ps
// One restoring division step for the three normal components.
module dsn_div_cell import dsn_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  dv_data_t data_i,
  output logic     valid_o,
  output dv_data_t data_o
);

  logic [DEN_W:0] cur [3];
  dv_data_t       data_d;
  dv_data_t       data_q;
  logic           valid_q;

  always_comb begin
    data_d = data_i;
    for (int i = 0; i < 3; i++) begin
      cur[i] = {data_i.rem[i], data_i.low[i][QUO_W-1]};
      data_d.low[i] = data_i.low[i] << 1;
      if (cur[i] >= {1'b0, data_i.den}) begin
        data_d.rem[i] = DEN_W'(cur[i] - {1'b0, data_i.den});
        data_d.quo[i] = {data_i.quo[i][QUO_W-2:0], 1'b1};
      end else begin
        data_d.rem[i] = DEN_W'(cur[i]);
        data_d.quo[i] = {data_i.quo[i][QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
